// File: hdl/btpc_pkg.sv
package btpc_pkg;

    localparam int RegIdxW = 2;
    localparam int CfgDataW = 64;

    localparam logic [RegIdxW-1:0] REG_TEMP_CALIB = 2'd0;
    localparam logic [RegIdxW-1:0] REG_PRESS_A = 2'd1;
    localparam logic [RegIdxW-1:0] REG_PRESS_B = 2'd2;
    localparam logic [RegIdxW-1:0] REG_PRESS_C = 2'd3;

    localparam int DivSteps = 64;

    typedef struct packed {
        logic [7:0] press_msb;
        logic [7:0] press_lsb;
        logic [7:0] press_xlsb;
        logic [7:0] temp_msb;
        logic [7:0] temp_lsb;
        logic [7:0] temp_xlsb;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic [31:0] pressure_q8;
        logic pressure_valid;
    } out_item_t;

endpackage

// File: hdl/btpc_if.sv
interface btpc_if #(
    parameter type item_t = logic
);
    logic valid;
    logic ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/btpc_div.sv
module btpc_div (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_vld,
    input  logic [63:0] num,
    input  logic [63:0] den,
    input  logic neg,
    input  logic [63:0] side_in,
    output logic out_vld,
    output logic [63:0] quo,
    output logic [63:0] side_out
);
    import btpc_pkg::*;

    // one restoring step per stage, fully pipelined
    genvar g;
    generate
        for (g = 0; g < DivSteps; g++)
        begin : g_st
            logic v_in;
            logic n_in;
            logic [63:0] r_in, q_in, d_in, s_in;
            logic v_reg;
            logic n_reg;
            logic [63:0] r_reg, q_reg, d_reg, s_reg;
            logic [64:0] sh;
            logic [64:0] df;
            if (g == 0)
            begin : g_src
                assign v_in = in_vld;
                assign r_in = '0;
                assign q_in = num;
                assign d_in = den;
                assign n_in = neg;
                assign s_in = side_in;
            end
            else
            begin : g_src
                assign v_in = g_st[g-1].v_reg;
                assign r_in = g_st[g-1].r_reg;
                assign q_in = g_st[g-1].q_reg;
                assign d_in = g_st[g-1].d_reg;
                assign n_in = g_st[g-1].n_reg;
                assign s_in = g_st[g-1].s_reg;
            end
            assign sh = {r_in, q_in[63]};
            assign df = sh - {1'b0, d_in};
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg <= 1'b0;
                else if (en)
                    v_reg <= v_in;
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg <= df[64] ? sh[63:0] : df[63:0];
                    q_reg <= {q_in[62:0], ~df[64]};
                    d_reg <= d_in;
                    n_reg <= n_in;
                    s_reg <= s_in;
                end
            end
        end
    endgenerate

    assign out_vld = g_st[DivSteps-1].v_reg;
    assign quo = g_st[DivSteps-1].n_reg ? 64'd0 - g_st[DivSteps-1].q_reg
                                        : g_st[DivSteps-1].q_reg;
    assign side_out = g_st[DivSteps-1].s_reg;
endmodule

// File: hdl/baro_temp_pressure_compensate.sv
// channel  dir  payload
// in_ch    in   six raw burst bytes
// out_ch   out  temperature_centi, pressure_q8, pressure_valid
// one item per cycle while the output is not stalled; 8 compute stages, 64 divider stages,
// 4 post stages and the output register
// reset clears valid bits only, calibration registers clear to zero
// a stall at the output freezes the whole pipeline; ready follows the
// output register being empty or taken
module baro_temp_pressure_compensate (
    input  logic clk,
    input  logic rst_n,
    btpc_if.sink in_ch,
    btpc_if.source out_ch,
    input  logic cfg_we,
    input  logic [btpc_pkg::RegIdxW-1:0] cfg_idx,
    input  logic [btpc_pkg::CfgDataW-1:0] cfg_wdata
);
    import btpc_pkg::*;

    logic [47:0] tcal_reg;
    logic [63:0] pa_reg, pb_reg;
    logic [15:0] pc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcal_reg <= '0;
            pa_reg <= '0;
            pb_reg <= '0;
            pc_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_TEMP_CALIB: tcal_reg <= cfg_wdata[47:0];
                REG_PRESS_A: pa_reg <= cfg_wdata;
                REG_PRESS_B: pb_reg <= cfg_wdata;
                REG_PRESS_C: pc_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    function automatic logic [63:0] sx(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // 64 by signed 16 product, low 64 bits
    function automatic logic [63:0] mul16(input logic [63:0] a, input logic [15:0] b);
        return $signed(a) * 64'($signed(b));
    endfunction

    // 64 by unsigned 16 product, low 64 bits
    function automatic logic [63:0] mulu16(input logic [63:0] a, input logic [15:0] b);
        return a * {48'd0, b};
    endfunction

    logic [31:0] t1, t2, t3;
    logic [63:0] p4, p7;
    assign t1 = {16'd0, tcal_reg[15:0]};
    assign t2 = {{16{tcal_reg[31]}}, tcal_reg[31:16]};
    assign t3 = {{16{tcal_reg[47]}}, tcal_reg[47:32]};
    assign p4 = sx(pa_reg[63:48]);
    assign p7 = sx(pb_reg[47:32]);

    // global stall: everything moves when output can take
    logic en;
    logic ov_reg;
    out_item_t od_reg;
    assign en = !ov_reg || out_ch.ready;
    assign in_ch.ready = en;

    // stage 1: unpack, temperature products
    logic v1_reg;
    logic [19:0] rp1_reg;
    logic [31:0] ta1_reg, dd1_reg;
    logic [19:0] rt, rp;
    logic [31:0] dd;
    assign rp = {in_ch.data.press_msb, in_ch.data.press_lsb, in_ch.data.press_xlsb[7:4]};
    assign rt = {in_ch.data.temp_msb, in_ch.data.temp_lsb, in_ch.data.temp_xlsb[7:4]};
    assign dd = {16'd0, rt[19:4]} - t1;

    // stage 2
    logic v2_reg;
    logic [19:0] rp2_reg;
    logic [31:0] ta2_reg, b2_reg;
    logic [31:0] dsh;
    assign dsh = $signed(dd1_reg) >>> 12;
    // stage 3
    logic v3_reg;
    logic [19:0] rp3_reg;
    logic [31:0] tf3_reg;
    logic [31:0] b3;
    assign b3 = $signed(b2_reg) >>> 14;

    // stage 4: v1
    logic v4_reg;
    logic [19:0] rp4_reg;
    logic [31:0] tf4_reg;
    logic [63:0] x4_reg;
    logic [63:0] tf64;
    assign tf64 = {{32{tf3_reg[31]}}, tf3_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp1_reg <= rp;
            ta1_reg <= ({15'd0, rt[19:3]} - (t1 << 1)) * t2;
            dd1_reg <= dd * dd;
            rp2_reg <= rp1_reg;
            ta2_reg <= $signed(ta1_reg) >>> 11;
            b2_reg <= dsh * t3;
            rp3_reg <= rp2_reg;
            tf3_reg <= ta2_reg + b3;
            rp4_reg <= rp3_reg;
            tf4_reg <= tf3_reg;
            x4_reg <= tf64 - 64'd128000;
        end
    end

    // x4 fits in 33 signed bits
    logic signed [65:0] sqf;
    logic signed [48:0] m5, m2;
    assign sqf = 66'($signed(x4_reg[32:0])) * 66'($signed(x4_reg[32:0]));
    assign m5 = 49'($signed(x4_reg[32:0])) * 49'($signed(pb_reg[15:0]));
    assign m2 = 49'($signed(x4_reg[32:0])) * 49'($signed(pa_reg[31:16]));

    // stage 5: square and linear products
    logic v5_reg;
    logic [19:0] rp5_reg;
    logic [31:0] tf5_reg;
    logic [63:0] sq5_reg, l5a_reg, l2_5_reg;
    // stage 6
    logic v6_reg;
    logic [19:0] rp6_reg;
    logic [31:0] tf6_reg;
    logic [63:0] v2a6_reg, s3_6_reg, l2_6_reg;
    // stage 7
    logic v7_reg;
    logic [19:0] rp7_reg;
    logic [31:0] tf7_reg;
    logic [63:0] v2_7_reg, v1_7_reg;
    // stage 8
    logic v8_reg;
    logic [31:0] tf8_reg;
    logic [63:0] num8_reg, v1_8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp5_reg <= rp4_reg;
            tf5_reg <= tf4_reg;
            sq5_reg <= sqf[63:0];
            l5a_reg <= {m5[46:0], 17'd0};
            l2_5_reg <= {{3{m2[48]}}, m2, 12'd0};
            rp6_reg <= rp5_reg;
            tf6_reg <= tf5_reg;
            v2a6_reg <= mul16(sq5_reg, pb_reg[31:16]) + l5a_reg + (p4 << 35);
            s3_6_reg <= $signed(mul16(sq5_reg, pa_reg[47:32])) >>> 8;
            l2_6_reg <= l2_5_reg;
            rp7_reg <= rp6_reg;
            tf7_reg <= tf6_reg;
            v2_7_reg <= v2a6_reg;
            v1_7_reg <= $signed(mulu16(s3_6_reg + l2_6_reg + 64'h0000_8000_0000_0000,
                                       pa_reg[15:0])) >>> 33;
            tf8_reg <= tf7_reg;
            num8_reg <= ((({44'd0, 20'd0} + 64'd1048576 - {44'd0, rp7_reg}) << 31) - v2_7_reg)
                        * 64'd3125;
            v1_8_reg <= v1_7_reg;
        end
    end

    // divider on magnitudes; divisor zero flagged through side data
    logic [63:0] an, ad;
    assign an = num8_reg[63] ? 64'd0 - num8_reg : num8_reg;
    assign ad = v1_8_reg[63] ? 64'd0 - v1_8_reg : v1_8_reg;

    logic dv_vld;
    logic [63:0] dq, dside;
    btpc_div u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v8_reg),
        .num(an), .den(ad), .neg(num8_reg[63] ^ v1_8_reg[63]),
        .side_in({31'd0, v1_8_reg == 64'd0, tf8_reg}),
        .out_vld(dv_vld), .quo(dq), .side_out(dside)
    );

    // post stages
    logic v9_reg, v10_reg, v11_reg, v12_reg;
    logic z9_reg, z10_reg, z11_reg, z12_reg;
    logic [31:0] tf9_reg;
    logic [63:0] p9_reg, h9_reg;
    logic [15:0] tc10_reg, tc11_reg, tc12_reg;
    logic [63:0] p10_reg, hh10_reg, w2_10_reg;
    logic [63:0] p11_reg, w1_11_reg, w2_11_reg;
    logic [63:0] pr12_reg;
    logic [31:0] tcw;
    logic [15:0] tcs;
    logic [63:0] hll;
    logic [31:0] hlh;
    logic [63:0] pr11;

    // h*h from 32-bit halves
    assign hll = 64'(h9_reg[31:0]) * 64'(h9_reg[31:0]);
    assign hlh = h9_reg[63:32] * h9_reg[31:0];
    assign pr11 = $signed(w1_11_reg + w2_11_reg + p11_reg) >>> 8;

    assign tcw = $signed(tf9_reg * 32'd5 + 32'd128) >>> 8;
    always_comb
    begin
        if ($signed(tcw) > 32'sd32767)
            tcs = 16'h7fff;
        else if ($signed(tcw) < -32'sd32768)
            tcs = 16'h8000;
        else
            tcs = tcw[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v9_reg <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v9_reg <= dv_vld;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
            ov_reg <= v12_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z9_reg <= dside[32];
            tf9_reg <= dside[31:0];
            p9_reg <= dq;
            h9_reg <= $signed(dq) >>> 13;
            z10_reg <= z9_reg;
            tc10_reg <= tcs;
            p10_reg <= p9_reg;
            hh10_reg <= hll + {hlh[30:0], 33'd0};
            w2_10_reg <= $signed(mul16(p9_reg, pb_reg[63:48])) >>> 19;
            z11_reg <= z10_reg;
            tc11_reg <= tc10_reg;
            p11_reg <= p10_reg;
            w1_11_reg <= $signed(mul16(hh10_reg, pc_reg)) >>> 25;
            w2_11_reg <= w2_10_reg;
            z12_reg <= z11_reg;
            tc12_reg <= tc11_reg;
            pr12_reg <= pr11 + (p7 << 4);
            od_reg.temperature_centi <= tc12_reg;
            od_reg.pressure_q8 <= z12_reg ? 32'd0 : pr12_reg[31:0];
            od_reg.pressure_valid <= !z12_reg;
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.data = od_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("output item changed under stall");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.data.pressure_valid |-> out_ch.data.pressure_q8 == 32'd0)
        else $error("invalid pressure not zero");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input stalled with empty output");
endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import btpc_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [RegIdxW-1:0] cfg_idx = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;

    btpc_if #(.item_t(in_item_t)) in_ch ();
    btpc_if #(.item_t(out_item_t)) out_ch ();

    baro_temp_pressure_compensate dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_wdata(cfg_wdata)
    );

    logic [47:0] temp_calib;
    logic [63:0] press_a;
    logic [63:0] press_b;
    logic [15:0] press_c;

    out_item_t compensated_q[$];
    int errors = 0;
    longint unsigned cycles = 0;
    bit hold_off = 1'b0;
    bit sink_idle = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [63:0] sdiv(logic signed [63:0] a, logic signed [63:0] b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        begin
            ua = a[63] ? -a : a;
            ub = b[63] ? -b : b;
            q = ua / ub;
            return (a[63] != b[63]) ? -q : q;
        end
    endfunction

    function automatic out_item_t compensate(in_item_t it);
        out_item_t r;
        logic [31:0] raw_p;
        logic [31:0] raw_t;
        logic [31:0] t1;
        logic signed [31:0] t2;
        logic signed [31:0] t3;
        logic signed [31:0] d;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] tfine;
        logic signed [31:0] tc;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] v1, v2, sq, p, h, w1, w2;
        begin
            raw_p = {12'd0, it.press_msb, it.press_lsb, it.press_xlsb[7:4]};
            raw_t = {12'd0, it.temp_msb, it.temp_lsb, it.temp_xlsb[7:4]};
            t1 = {16'd0, temp_calib[15:0]};
            t2 = 32'(signed'(temp_calib[31:16]));
            t3 = 32'(signed'(temp_calib[47:32]));
            p1 = {48'd0, press_a[15:0]};
            p2 = 64'(signed'(press_a[31:16]));
            p3 = 64'(signed'(press_a[47:32]));
            p4 = 64'(signed'(press_a[63:48]));
            p5 = 64'(signed'(press_b[15:0]));
            p6 = 64'(signed'(press_b[31:16]));
            p7 = 64'(signed'(press_b[47:32]));
            p8 = 64'(signed'(press_b[63:48]));
            p9 = 64'(signed'(press_c));

            d = (raw_t >> 4) - t1;
            a = ((raw_t >> 3) - (t1 << 1)) * t2;
            a = a >>> 11;
            b = d * d;
            b = b >>> 12;
            b = b * t3;
            b = b >>> 14;
            tfine = a + b;
            tc = tfine * 5 + 128;
            tc = tc >>> 8;
            if (tc > 32767)
                r.temperature_centi = 16'sd32767;
            else if (tc < -32768)
                r.temperature_centi = -16'sd32768;
            else
                r.temperature_centi = tc[15:0];

            v1 = 64'(tfine) - 64'sd128000;
            sq = v1 * v1;
            v2 = sq * p6 + ((v1 * p5) << 17) + (p4 << 35);
            v1 = ((sq * p3) >>> 8) + ((v1 * p2) << 12);
            v1 = ((v1 + (64'sd1 << 47)) * p1) >>> 33;
            r.pressure_q8 = '0;
            r.pressure_valid = 1'b0;
            if (v1 != 0)
            begin
                p = ((64'sd1048576 - 64'(raw_p)) << 31) - v2;
                p = sdiv(p * 64'sd3125, v1);
                h = p >>> 13;
                w1 = (p9 * h * h) >>> 25;
                w2 = (p8 * p) >>> 19;
                p = ((w1 + w2 + p) >>> 8) + (p7 << 4);
                r.pressure_q8 = p[31:0];
                r.pressure_valid = 1'b1;
            end
            return r;
        end
    endfunction

    // sink side
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (compensated_q.size() == 0)
            begin
                $error("unexpected item %p", out_ch.data);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = compensated_q.pop_front();
                if (out_ch.data.temperature_centi !== e.temperature_centi)
                begin
                    $error("temperature_centi exp %0d got %0d", e.temperature_centi,
                        out_ch.data.temperature_centi);
                    errors++;
                end
                if (out_ch.data.pressure_q8 !== e.pressure_q8)
                begin
                    $error("pressure_q8 exp %h got %h", e.pressure_q8, out_ch.data.pressure_q8);
                    errors++;
                end
                if (out_ch.data.pressure_valid !== e.pressure_valid)
                begin
                    $error("pressure_valid exp %b got %b", e.pressure_valid,
                        out_ch.data.pressure_valid);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            w = (sink_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            if (w > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    task automatic send_item(in_item_t it, bit no_gap = 1'b0);
        int w;
        begin
            w = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (w > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (w) @(posedge clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.data <= it;
            compensated_q.push_back(compensate(it));
            @(posedge clk);
            while (!in_ch.ready) @(posedge clk);
        end
    endtask

    task automatic drain();
        begin
            in_ch.valid <= 1'b0;
            while (compensated_q.size() != 0) @(posedge clk);
            repeat (100) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [RegIdxW-1:0] idx, logic [63:0] val);
        begin
            cfg_we <= 1'b1;
            cfg_idx <= idx;
            cfg_wdata <= val;
            case (idx)
                REG_TEMP_CALIB: temp_calib = val[47:0];
                REG_PRESS_A: press_a = val;
                REG_PRESS_B: press_b = val;
                default: press_c = val[15:0];
            endcase
            @(posedge clk);
        end
    endtask

    function automatic in_item_t rand_item();
        in_item_t it;
        logic [63:0] r;
        begin
            r = {$urandom, $urandom};
            it = r[47:0];
            return it;
        end
    endfunction

    task automatic set_calib(logic [47:0] t, logic [63:0] a, logic [63:0] b, logic [15:0] c);
        begin
            write_reg(REG_TEMP_CALIB, {16'd0, t});
            write_reg(REG_PRESS_A, a);
            write_reg(REG_PRESS_B, b);
            write_reg(REG_PRESS_C, {48'd0, c});
            cfg_we <= 1'b0;
        end
    endtask

    // typical sensor calibration
    task automatic set_typical();
        begin
            set_calib({16'sd50, 16'sd26435, 16'd27504},
                {16'sd2855, 16'sd8004, -16'sd10685, 16'd36477},
                {16'sd15500, -16'sd14600, -16'sd7, 16'sd140},
                16'sd6000);
        end
    endtask

    task automatic test_zero_calib();
        begin
            send_item('0);
            send_item('1);
            send_item(rand_item());
            drain();
        end
    endtask

    task automatic test_extremes();
        in_item_t it;
        begin
            set_typical();
            send_item('0);
            send_item('1);
            it = '0;
            it.press_msb = 8'h80;
            it.temp_msb = 8'h80;
            send_item(it);
            it = 48'h0F0F0F0F0F0F;
            send_item(it);
            it = 48'hF0F0F0F0F0F0;
            send_item(it);
            it = {8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00};
            send_item(it);
            drain();
            set_calib('1, '1, '1, '1);
            send_item('0);
            send_item('1);
            send_item(rand_item());
            drain();
            set_calib({16'h8000, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
            send_item('0);
            send_item('1);
            send_item(rand_item());
            drain();
            // zero divisor with p1 cleared
            set_calib({16'sd50, 16'sd26435, 16'd27504}, '0, '0, '0);
            send_item(rand_item());
            send_item('1);
            drain();
        end
    endtask

    task automatic test_random(int n);
        int k;
        begin
            for (int i = 0; i < n; i++)
            begin
                if (i % 100 == 0)
                begin
                    drain();
                    k = $urandom_range(0, 4);
                    if (k == 0)
                        set_typical();
                    else if (k == 1)
                        set_calib(48'({$urandom, $urandom}), {$urandom, $urandom},
                            {$urandom, $urandom}, 16'($urandom));
                    else
                        set_calib({16'($urandom_range(0, 200) - 100), 16'($urandom),
                            16'($urandom_range(20000, 40000))},
                            {16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom_range(30000, 40000))},
                            {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
                            16'($urandom));
                    sink_idle = (k == 4);
                end
                send_item(rand_item());
            end
            sink_idle = 1'b0;
            drain();
        end
    endtask

    task automatic test_backpressure();
        begin
            set_typical();
            hold_off = 1'b1;
            for (int i = 0; i < 150; i++)
                send_item(rand_item(), 1'b1);
            drain();
            for (int i = 0; i < 10; i++)
                send_item(rand_item());
            drain();
        end
    endtask

    initial
    begin
        temp_calib = '0;
        press_a = '0;
        press_b = '0;
        press_c = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_calib();
        test_extremes();
        test_backpressure();
        test_random(780);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
